// File: design/rdcp_pkg.sv
// Shared types and constants for the register dump command parser.
package rdcp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  reg_address;
    logic [7:0]  reg_value;
    logic [16:0] wait_ticks;
    logic        burst_end;
    logic [15:0] tick_resolution;
  } out_word_t;

  typedef enum logic [3:0] {
    ACT_WRITE     = 4'd0,
    ACT_BURST     = 4'd1,
    ACT_CHIP_SEL  = 4'd2,
    ACT_HW_RESET  = 4'd3,
    ACT_FLUSH     = 4'd4,
    ACT_WAIT      = 4'd5,
    ACT_HEADER_OK = 4'd6,
    ACT_BAD_MAGIC = 4'd7,
    ACT_BAD_HDR   = 4'd8,
    ACT_BAD_CMD   = 4'd9
  } action_e;

  // Classified result waiting for the back end; aux_hi/aux_lo carry the
  // wait count or the resolution before formatting.
  typedef struct packed {
    action_e    action;
    logic [7:0] reg_address;
    logic [7:0] reg_value;
    logic [7:0] aux_hi;
    logic [7:0] aux_lo;
    logic       burst_end;
  } qent_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [4:0] level;
  } qstat_t;

  localparam logic [7:0] CMD_NOP       = 8'h00;
  localparam logic [7:0] CMD_WRITE     = 8'h01;
  localparam logic [7:0] CMD_BURST     = 8'h02;
  localparam logic [7:0] CMD_CHIP_SEL  = 8'h80;
  localparam logic [7:0] CMD_HW_RESET  = 8'hf0;
  localparam logic [7:0] CMD_FLUSH     = 8'hf8;
  localparam logic [7:0] CMD_WAIT_A    = 8'hfd;
  localparam logic [7:0] CMD_WAIT_B    = 8'hfe;
  localparam logic [7:0] CMD_WAIT_ONE  = 8'hff;

  localparam logic [3:0] HDR_LAST      = 4'd15;
  localparam logic [3:0] HDR_PAD_FIRST = 4'd6;
  localparam logic [3:0] HDR_RES_LO    = 4'd8;
  localparam logic [3:0] HDR_RES_HI    = 4'd9;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h59;
      3'd1:    b = 8'h4D;
      3'd2:    b = 8'h46;
      3'd3:    b = 8'h38;
      3'd4:    b = 8'h32;
      3'd5:    b = 8'h35;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/rdcp_front.sv
// Front end: walks the header and command grammar one word at a time.
module rdcp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  rdcp_pkg::in_word_t word_i,
  output logic              push_o,
  output rdcp_pkg::qent_t   entry_o
);
  import rdcp_pkg::*;

  typedef enum logic [9:0] {
    PH_HEAD    = 10'b00_0000_0001,
    PH_CMD     = 10'b00_0000_0010,
    PH_ADDR    = 10'b00_0000_0100,
    PH_WVAL    = 10'b00_0000_1000,
    PH_LEN_LO  = 10'b00_0001_0000,
    PH_LEN_HI  = 10'b00_0010_0000,
    PH_BURST   = 10'b00_0100_0000,
    PH_CHIP    = 10'b00_1000_0000,
    PH_WAIT_LO = 10'b01_0000_0000,
    PH_WAIT_HI = 10'b10_0000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  hpos_q, hpos_d;
  logic        halted_q, halted_d;
  logic        is_write_q, is_write_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] remain_q, remain_d;

  logic [7:0]  d;
  logic        hit;
  qent_t       ent;

  assign d = word_i.data_byte;

  always_comb begin
    phase_d    = phase_q;
    hpos_d     = hpos_q;
    halted_d   = halted_q;
    is_write_d = is_write_q;
    addr_d     = addr_q;
    low_d      = low_q;
    remain_d   = remain_q;
    hit        = 1'b0;
    ent        = '{action: ACT_WRITE, reg_address: 8'h00, reg_value: 8'h00,
                   aux_hi: 8'h00, aux_lo: 8'h00, burst_end: 1'b0};

    if (!halted_q) begin
      case (phase_q)
        PH_HEAD: begin
          if (hpos_q < HDR_PAD_FIRST) begin
            if (d != magic_byte(hpos_q[2:0])) begin
              hit        = 1'b1;
              ent.action = ACT_BAD_MAGIC;
              halted_d   = 1'b1;
            end
          end else if (hpos_q < HDR_RES_LO) begin
            if (d != 8'h00) begin
              hit        = 1'b1;
              ent.action = ACT_BAD_HDR;
              halted_d   = 1'b1;
            end
          end else if (hpos_q == HDR_RES_LO) begin
            low_d = d;
          end else if (hpos_q == HDR_RES_HI) begin
            hit        = 1'b1;
            ent.action = ACT_HEADER_OK;
            ent.aux_lo = low_q;
            ent.aux_hi = d;
          end
          if (hpos_q == HDR_LAST) begin
            hpos_d  = 4'd0;
            phase_d = PH_CMD;
          end else begin
            hpos_d = hpos_q + 4'd1;
          end
        end
        PH_CMD: begin
          is_write_d = (d == CMD_WRITE);
          case (d)
            CMD_NOP: ;
            CMD_WRITE, CMD_BURST: phase_d = PH_ADDR;
            CMD_CHIP_SEL: phase_d = PH_CHIP;
            CMD_HW_RESET: begin
              hit        = 1'b1;
              ent.action = ACT_HW_RESET;
            end
            CMD_FLUSH: begin
              hit        = 1'b1;
              ent.action = ACT_FLUSH;
            end
            CMD_WAIT_A, CMD_WAIT_B: phase_d = PH_WAIT_LO;
            CMD_WAIT_ONE: begin
              hit        = 1'b1;
              ent.action = ACT_WAIT;
            end
            default: begin
              hit           = 1'b1;
              ent.action    = ACT_BAD_CMD;
              ent.reg_value = d;
              halted_d      = 1'b1;
            end
          endcase
        end
        PH_ADDR: begin
          addr_d  = d;
          phase_d = is_write_q ? PH_WVAL : PH_LEN_LO;
        end
        PH_WVAL: begin
          hit             = 1'b1;
          ent.action      = ACT_WRITE;
          ent.reg_address = addr_q;
          ent.reg_value   = d;
          phase_d         = PH_CMD;
        end
        PH_LEN_LO: begin
          low_d   = d;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          remain_d = {d, low_q};
          phase_d  = ({d, low_q} == 16'd0) ? PH_CMD : PH_BURST;
        end
        PH_BURST: begin
          hit             = 1'b1;
          ent.action      = ACT_BURST;
          ent.reg_address = addr_q;
          ent.reg_value   = d;
          ent.burst_end   = (remain_q == 16'd1);
          remain_d        = remain_q - 16'd1;
          if (remain_q == 16'd1) begin
            phase_d = PH_CMD;
          end
        end
        PH_CHIP: begin
          hit           = 1'b1;
          ent.action    = ACT_CHIP_SEL;
          ent.reg_value = d;
          phase_d       = PH_CMD;
        end
        PH_WAIT_LO: begin
          low_d   = d;
          phase_d = PH_WAIT_HI;
        end
        PH_WAIT_HI: begin
          hit        = 1'b1;
          ent.action = ACT_WAIT;
          ent.aux_lo = low_q;
          ent.aux_hi = d;
          phase_d    = PH_CMD;
        end
        default: phase_d = PH_CMD;
      endcase
    end

    // Drop any partial command or header on the final word.
    if (word_i.last_byte) begin
      phase_d  = PH_HEAD;
      hpos_d   = 4'd0;
      halted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEAD;
      hpos_q     <= 4'd0;
      halted_q   <= 1'b0;
      is_write_q <= 1'b0;
      remain_q   <= 16'd0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      hpos_q     <= hpos_d;
      halted_q   <= halted_d;
      is_write_q <= is_write_d;
      remain_q   <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      addr_q <= addr_d;
      low_q  <= low_d;
    end
  end

  assign push_o  = take_i && hit;
  assign entry_o = ent;

endmodule

// File: design/rdcp_fifo.sv
// Short queue of classified results between front and back end.
module rdcp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rdcp_pkg::qent_t entry_i,
  input  logic            pop_i,
  output rdcp_pkg::qent_t entry_o,
  output rdcp_pkg::qstat_t stat_o
);
  import rdcp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  qent_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign do_push = push_i && (cnt_q != CntFull);
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign entry_o      = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.level = 5'(cnt_q);

endmodule

// File: design/rdcp_back.sv
// Back end: formats queued results into the output register.
module rdcp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  rdcp_pkg::qent_t    entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rdcp_pkg::out_word_t out_word_o
);
  import rdcp_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q, word_d;

  // Refill the output register whenever it is empty or being taken.
  assign pop_o = avail_i && (!valid_q || !out_stall_i);

  always_comb begin
    word_d.action          = 4'(entry_i.action);
    word_d.reg_address     = entry_i.reg_address;
    word_d.reg_value       = entry_i.reg_value;
    word_d.burst_end       = entry_i.burst_end;
    word_d.wait_ticks      = 17'd0;
    word_d.tick_resolution = 16'd0;
    if (entry_i.action == ACT_WAIT) begin
      word_d.wait_ticks = {1'b0, entry_i.aux_hi, entry_i.aux_lo} + 17'd1;
    end
    if (entry_i.action == ACT_HEADER_OK) begin
      word_d.tick_resolution = {entry_i.aux_hi, entry_i.aux_lo};
    end
    valid_d = pop_o ? 1'b1 : (valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// File: design/register_dump_command_parser.sv
// Top level of the register dump command parser.
// Usage:
//   Input channel: one dump byte per word (data_byte, last_byte) on in_word_i,
//   taken at a clock edge where in_valid_i is high and in_stall_o is low.
//   The first sixteen words are the header; command words follow. Set
//   last_byte on the final word of a dump to return the parser to header start.
//   Output channel: at most one result word per input word on out_word_o,
//   taken where out_valid_o is high and out_stall_i is low.
// Timing:
//   One input word per cycle while in_stall_o is low. A result is written into
//   the result queue at the edge that takes its input word, then moved from the
//   queue into the output register that drives out_valid_o.
// Stalls:
//   While out_stall_i is high the output word holds and result words collect
//   in the queue; in_stall_o rises once the queue is full and holds every
//   input word, with or without a result, until the output word is taken.
// Reset:
//   rst_ni clears the parse state to header start, empties the queue and
//   drops out_valid_o. No result is lost or repeated across a stall.
module register_dump_command_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rdcp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rdcp_pkg::out_word_t out_word_o
);
  import rdcp_pkg::*;

  logic   take;
  logic   push;
  logic   pop;
  qent_t  push_ent;
  qent_t  head_ent;
  qstat_t qstat;

  // Hold the input while the queue has no room for a possible result.
  assign in_stall_o = qstat.full;
  assign take       = in_valid_i && !qstat.full;

  rdcp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .word_i  (in_word_i),
    .push_o  (push),
    .entry_o (push_ent)
  );

  rdcp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_ent),
    .pop_i   (pop),
    .entry_o (head_ent),
    .stat_o  (qstat)
  );

  rdcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (!qstat.empty),
    .entry_i     (head_ent),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(qstat.level) <= QueueDepth)
    else $error("result queue overfilled");

  // A push into a full queue would lose a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into full queue");

  // Burst end only flags a burst byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.burst_end) |-> (out_word_o.action == 4'(ACT_BURST)))
    else $error("burst end on non-burst result");

  // A wait always carries a nonzero tick count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.action == 4'(ACT_WAIT)) |-> (out_word_o.wait_ticks != 17'd0))
    else $error("wait with zero ticks");

endmodule

// File: dv/dump_action_checker.sv
// Checker for the register dump command parser: predicts each result word and compares it.
`timescale 1ns / 100ps

module dump_action_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rdcp_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rdcp_pkg::out_word_t out_word_i,
  output int                  mismatch_count,
  output int                  pending_count
);
  import rdcp_pkg::*;

  // Expected header signature, first byte in the top bits.
  localparam logic [47:0] SIGNATURE = 48'h59_4D_46_38_32_35;

  typedef enum logic [3:0] {
    ST_HEADER, ST_COMMAND, ST_ADDRESS, ST_WRITE_VALUE, ST_LEN_LO,
    ST_LEN_HI, ST_BURST, ST_CHIP, ST_WAIT_LO, ST_WAIT_HI
  } parse_phase_e;

  parse_phase_e phase;
  logic [3:0]   hdr_pos;
  logic [7:0]   cmd_byte;
  logic [7:0]   addr_hold;
  logic [7:0]   low_hold;
  logic [15:0]  burst_left;
  logic         halted;
  out_word_t    actions_due[$];

  task automatic clear_state();
    phase      = ST_HEADER;
    hdr_pos    = '0;
    cmd_byte   = '0;
    addr_hold  = '0;
    low_hold   = '0;
    burst_left = '0;
    halted     = 1'b0;
  endtask

  task automatic queue_action(input action_e act, input logic [7:0] addr,
                              input logic [7:0] val, input logic [16:0] ticks,
                              input logic last_of_burst, input logic [15:0] res);
    out_word_t w;
    w.action          = act;
    w.reg_address     = addr;
    w.reg_value       = val;
    w.wait_ticks      = ticks;
    w.burst_end       = last_of_burst;
    w.tick_resolution = res;
    actions_due.push_back(w);
  endtask

  // Advance the parse state by one dump byte.
  task automatic parse_byte(input in_word_t w);
    logic [7:0] d;
    d = w.data_byte;
    if (!halted) begin
      case (phase)
        ST_HEADER: begin
          if (hdr_pos < HDR_PAD_FIRST) begin
            if (d != SIGNATURE[47 - 8 * hdr_pos -: 8]) begin
              queue_action(ACT_BAD_MAGIC, '0, '0, '0, 1'b0, '0);
              halted = 1'b1;
            end
          end else if (hdr_pos < HDR_RES_LO) begin
            if (d != 8'h00) begin
              queue_action(ACT_BAD_HDR, '0, '0, '0, 1'b0, '0);
              halted = 1'b1;
            end
          end else if (hdr_pos == HDR_RES_LO) begin
            low_hold = d;
          end else if (hdr_pos == HDR_RES_HI) begin
            queue_action(ACT_HEADER_OK, '0, '0, '0, 1'b0, {d, low_hold});
          end
          if (hdr_pos == HDR_LAST) begin
            hdr_pos = '0;
            phase   = ST_COMMAND;
          end else begin
            hdr_pos = hdr_pos + 4'd1;
          end
        end
        ST_COMMAND: begin
          cmd_byte = d;
          case (d)
            CMD_NOP: ;
            CMD_WRITE, CMD_BURST: phase = ST_ADDRESS;
            CMD_CHIP_SEL: phase = ST_CHIP;
            CMD_HW_RESET: queue_action(ACT_HW_RESET, '0, '0, '0, 1'b0, '0);
            CMD_FLUSH: queue_action(ACT_FLUSH, '0, '0, '0, 1'b0, '0);
            CMD_WAIT_A, CMD_WAIT_B: phase = ST_WAIT_LO;
            CMD_WAIT_ONE: queue_action(ACT_WAIT, '0, '0, 17'd1, 1'b0, '0);
            default: begin
              queue_action(ACT_BAD_CMD, '0, d, '0, 1'b0, '0);
              halted = 1'b1;
            end
          endcase
        end
        ST_ADDRESS: begin
          addr_hold = d;
          phase = (cmd_byte == CMD_WRITE) ? ST_WRITE_VALUE : ST_LEN_LO;
        end
        ST_WRITE_VALUE: begin
          queue_action(ACT_WRITE, addr_hold, d, '0, 1'b0, '0);
          phase = ST_COMMAND;
        end
        ST_LEN_LO: begin
          low_hold = d;
          phase = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          burst_left = {d, low_hold};
          phase = (burst_left == 16'd0) ? ST_COMMAND : ST_BURST;
        end
        ST_BURST: begin
          queue_action(ACT_BURST, addr_hold, d, '0, burst_left == 16'd1, '0);
          burst_left = burst_left - 16'd1;
          if (burst_left == 16'd0) phase = ST_COMMAND;
        end
        ST_CHIP: begin
          queue_action(ACT_CHIP_SEL, '0, d, '0, 1'b0, '0);
          phase = ST_COMMAND;
        end
        ST_WAIT_LO: begin
          low_hold = d;
          phase = ST_WAIT_HI;
        end
        ST_WAIT_HI: begin
          queue_action(ACT_WAIT, '0, '0, {1'b0, d, low_hold} + 17'd1, 1'b0, '0);
          phase = ST_COMMAND;
        end
        default: phase = ST_COMMAND;
      endcase
    end
    if (w.last_byte) clear_state();
  endtask

  task automatic check_action(input out_word_t got);
    out_word_t want;
    logic      bad;
    if (actions_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result word action=%0d addr=%h val=%h ticks=%0d",
                 $time, got.action, got.reg_address, got.reg_value, got.wait_ticks);
    end else begin
      want = actions_due.pop_front();
      bad = (got.action !== want.action) || (got.reg_address !== want.reg_address) ||
            (got.reg_value !== want.reg_value) || (got.wait_ticks !== want.wait_ticks) ||
            (got.burst_end !== want.burst_end) ||
            (got.tick_resolution !== want.tick_resolution);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: mismatch exp act=%0d addr=%h val=%h ticks=%0d end=%b res=%h",
                   $time, want.action, want.reg_address, want.reg_value,
                   want.wait_ticks, want.burst_end, want.tick_resolution);
          $display("%0t:          got act=%0d addr=%h val=%h ticks=%0d end=%b res=%h",
                   $time, got.action, got.reg_address, got.reg_value,
                   got.wait_ticks, got.burst_end, got.tick_resolution);
        end
      end
    end
  endtask

  // Compare before predicting: a result taken at this edge always belongs to
  // an older byte.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      actions_due.delete();
      mismatch_count = 0;
      pending_count  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_action(out_word_i);
      if (in_valid_i && !in_stall_i) parse_byte(in_word_i);
      pending_count = actions_due.size();
    end
  end

endmodule

// File: dv/tb.sv
// Testbench top for the register dump command parser: stimulus, handshakes and verdict.
`timescale 1ns / 100ps

module tb;
  import rdcp_pkg::*;

  localparam int RANDOM_WORDS = 530;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 17;
  localparam int NO_FAULT     = 16;   // header position beyond the header: leave it intact

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      quiet     = 1'b0;   // high: neither side idles
  int        mismatches;
  int        pending;
  int        random_words = 0;
  logic [7:0] dump_q[$];         // bytes of the dump under construction

  register_dump_command_parser uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  dump_action_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .mismatch_count(mismatches),
    .pending_count (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure: random stall at each falling edge, none while quiet.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Guard against a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Bias towards the extremes so every field edge comes up often.
  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = 8'h00;
      1:       b = 8'hff;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Append a 16-byte header; bad_at names a position to corrupt, if any.
  function automatic void push_header(input logic [15:0] res, input int bad_at);
    logic [7:0] b;
    for (int i = 0; i < 16; i++) begin
      if (i < HDR_PAD_FIRST)     b = magic_byte(3'(i));
      else if (i < HDR_RES_LO)   b = 8'h00;
      else if (i == HDR_RES_LO)  b = res[7:0];
      else if (i == HDR_RES_HI)  b = res[15:8];
      else                       b = any_byte();
      if (i == bad_at)
        b = (i < HDR_PAD_FIRST) ? b ^ 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 255));
      dump_q.push_back(b);
    end
  endfunction

  function automatic void push_noise(input int n);
    repeat (n) dump_q.push_back(any_byte());
  endfunction

  // Drop trailing bytes so the dump ends mid-command or mid-header.
  function automatic void trim_to(input int n);
    while (dump_q.size() > n) void'(dump_q.pop_back());
  endfunction

  // Append one random command; returns 1 where the dump must end after it
  // (a burst too long to finish, or a command that halts the parser).
  function automatic bit push_command();
    logic [7:0] b;
    int         n;
    case ($urandom_range(0, 11))
      0: dump_q.push_back(CMD_NOP);
      1, 2, 11: begin
        dump_q.push_back(CMD_WRITE);
        dump_q.push_back(any_byte());
        dump_q.push_back(any_byte());
      end
      3, 4: begin
        dump_q.push_back(CMD_BURST);
        dump_q.push_back(any_byte());
        if ($urandom_range(0, 9) == 0) begin
          // long burst: high length byte set, cut short by the last byte
          dump_q.push_back(any_byte());
          dump_q.push_back(8'($urandom_range(1, 255)));
          push_noise($urandom_range(1, 4));
          return 1'b1;
        end
        n = $urandom_range(0, 5);
        dump_q.push_back(8'(n));
        dump_q.push_back(8'h00);
        push_noise(n);
      end
      5: begin
        dump_q.push_back(CMD_CHIP_SEL);
        dump_q.push_back(any_byte());
      end
      6: dump_q.push_back(CMD_HW_RESET);
      7: dump_q.push_back(CMD_FLUSH);
      8: begin
        dump_q.push_back($urandom_range(1) ? CMD_WAIT_A : CMD_WAIT_B);
        dump_q.push_back(any_byte());
        dump_q.push_back(any_byte());
      end
      9: dump_q.push_back(CMD_WAIT_ONE);
      default: begin
        if ($urandom_range(0, 3) != 0) begin
          dump_q.push_back(CMD_NOP);
        end else begin
          do b = 8'($urandom_range(255));
          while (b inside {CMD_NOP, CMD_WRITE, CMD_BURST, CMD_CHIP_SEL, CMD_HW_RESET,
                           CMD_FLUSH, CMD_WAIT_A, CMD_WAIT_B, CMD_WAIT_ONE});
          dump_q.push_back(b);
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // Offer one word; hold it until it is taken, then return at the next falling edge.
  task automatic send_word(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the built dump with last_byte on its final word, then clear it.
  task automatic send_dump();
    foreach (dump_q[i]) send_word(dump_q[i], i == dump_q.size() - 1);
    dump_q.delete();
  endtask

  // Hold the sender off until every predicted result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk);
    while (pending != 0);
  endtask

  initial begin
    int  kind;
    bit  drained;
    drained = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every command at least once, the field extremes, and a halt on an
    // unknown command with ignored bytes behind it.
    push_header(16'hffff, NO_FAULT);
    dump_q.push_back(CMD_NOP);
    dump_q.push_back(CMD_WRITE);    dump_q.push_back(8'h00); dump_q.push_back(8'hff);
    dump_q.push_back(CMD_BURST);    dump_q.push_back(8'hff);
    dump_q.push_back(8'h02);        dump_q.push_back(8'h00);
    dump_q.push_back(8'haa);        dump_q.push_back(8'h55);
    // zero-length burst: the next byte is a command again
    dump_q.push_back(CMD_BURST);    dump_q.push_back(8'h10);
    dump_q.push_back(8'h00);        dump_q.push_back(8'h00);
    dump_q.push_back(CMD_CHIP_SEL); dump_q.push_back(8'h03);
    dump_q.push_back(CMD_HW_RESET);
    dump_q.push_back(CMD_FLUSH);
    // longest wait must not wrap
    dump_q.push_back(CMD_WAIT_A);   dump_q.push_back(8'hff); dump_q.push_back(8'hff);
    dump_q.push_back(CMD_WAIT_B);   dump_q.push_back(8'h00); dump_q.push_back(8'h00);
    dump_q.push_back(CMD_WAIT_ONE);
    dump_q.push_back(8'h03);
    dump_q.push_back(CMD_WRITE);    dump_q.push_back(8'h42);
    send_dump();

    // result on the very last byte
    push_header(16'h0000, NO_FAULT);
    dump_q.push_back(CMD_WAIT_ONE);
    send_dump();

    // bad magic on the first byte, then on the last magic byte
    dump_q.push_back(8'h00);
    dump_q.push_back(8'h59);
    send_dump();
    push_header(16'h1234, 5);
    trim_to(8);
    send_dump();

    // non-zero pad byte
    push_header(16'h8001, 7);
    push_noise(3);
    send_dump();

    // truncated write, truncated header, header ending on the resolution
    push_header(16'h00ff, NO_FAULT);
    dump_q.push_back(CMD_WRITE);
    dump_q.push_back(8'h20);
    send_dump();
    push_header(16'h0000, NO_FAULT);
    trim_to(3);
    send_dump();
    push_header(16'hff00, NO_FAULT);
    trim_to(10);
    send_dump();

    wait_for_results();

    // Random dumps: mostly well-formed with random commands, some broken
    // headers and plain junk. A quiet stretch in the middle drops all idling.
    while (random_words < RANDOM_WORDS) begin
      quiet <= (random_words >= 250 && random_words < 400);
      if (!drained && random_words >= 250) begin
        wait_for_results();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        push_header({any_byte(), any_byte()}, $urandom_range(0, 7));
        push_noise($urandom_range(0, 6));
      end else if (kind == 3) begin
        push_noise($urandom_range(1, 20));
      end else begin
        push_header({any_byte(), any_byte()}, NO_FAULT);
        repeat ($urandom_range(1, 14)) begin
          if (push_command()) begin
            push_noise($urandom_range(0, 3));
            break;
          end
        end
        if ($urandom_range(0, 9) == 0) trim_to(dump_q.size() - $urandom_range(1, 3));
      end
      random_words += dump_q.size();
      send_dump();
    end

    wait_for_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
